>>> sv/fsrp_pkg.sv
// fsrp_pkg: shared constants, instruction codes, stage kinds and register and memory write-port types
// for the five-stage risc pipeline subset; no dependencies
`default_nettype none

package fsrp_pkg;

	localparam int MEM_BYTES = 2048;
	localparam int MEM_AW    = $clog2(MEM_BYTES);
	localparam int NREG      = 32;
	localparam int REG_AW    = $clog2(NREG);

	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_LB    = 6'h20;
	localparam logic [5:0] OP_SB    = 6'h28;
	localparam logic [5:0] FN_ADD   = 6'h20;
	localparam logic [5:0] FN_SUB   = 6'h22;

	typedef enum logic [2:0] {
		DK_BUBBLE = 3'd0,
		DK_ADD    = 3'd1,
		DK_SUB    = 3'd2,
		DK_LB     = 3'd3,
		DK_SB     = 3'd4
	} dec_kind_t;

	typedef enum logic [1:0] {
		EK_BUBBLE = 2'd0,
		EK_ALU    = 2'd1,
		EK_LOAD   = 2'd2,
		EK_STORE  = 2'd3
	} exe_kind_t;

	typedef struct packed {
		logic              en;
		logic [REG_AW-1:0] addr;
		logic [31:0]       data;
	} reg_wr_t;

	typedef struct packed {
		logic              en;
		logic [MEM_AW-1:0] addr;
		logic [7:0]        data;
	} mem_wr_t;

endpackage

`default_nettype wire

>>> sv/fsrp_regfile.sv
// fsrp_regfile: 32 x 32 register file, synchronous two-port read with registered read data
// per-entry valid bits give the reset pattern; uses fsrp_pkg
`default_nettype none

module fsrp_regfile import fsrp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [REG_AW-1:0] rs_addr,
	input  wire logic [REG_AW-1:0] rt_addr,
	input  wire reg_wr_t           wr,
	output logic [31:0]            rs_data,
	output logic [31:0]            rt_data
);

	function automatic logic [31:0] reg_reset(input logic [REG_AW-1:0] a);
		logic [31:0] v;
		v = (a == '0) ? 32'd0 : (32'(a) + 32'h100);
		return v;
	endfunction

	logic [31:0]       mem [NREG];
	logic [NREG-1:0]   vld_q;
	logic [31:0]       rs_raw_q, rt_raw_q, byp_data_q;
	logic [REG_AW-1:0] rs_addr_q, rt_addr_q;
	logic              rs_vld_q, rt_vld_q, rs_byp_q, rt_byp_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rs_raw_q   <= mem[rs_addr];
			rt_raw_q   <= mem[rt_addr];
			rs_addr_q  <= rs_addr;
			rt_addr_q  <= rt_addr;
			byp_data_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rs_vld_q <= 1'b0;
			rt_vld_q <= 1'b0;
			rs_byp_q <= 1'b0;
			rt_byp_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rs_vld_q <= vld_q[rs_addr];
				rt_vld_q <= vld_q[rt_addr];
				rs_byp_q <= wr.en && (wr.addr == rs_addr);
				rt_byp_q <= wr.en && (wr.addr == rt_addr);
			end
		end
	end

	assign rs_data = rs_byp_q ? byp_data_q : (rs_vld_q ? rs_raw_q : reg_reset(rs_addr_q));
	assign rt_data = rt_byp_q ? byp_data_q : (rt_vld_q ? rt_raw_q : reg_reset(rt_addr_q));

endmodule

`default_nettype wire

>>> sv/fsrp_dmem.sv
// fsrp_dmem: byte data memory, one read and one write port, registered read
// fills itself with address modulo 256 after reset; uses fsrp_pkg
`default_nettype none

module fsrp_dmem import fsrp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [MEM_AW-1:0] rd_addr,
	input  wire mem_wr_t           wr,
	output logic [7:0]             rd_data,
	output logic                   busy
);

	logic [7:0]        mem [MEM_BYTES];
	logic [7:0]        raw_q, byp_data_q;
	logic              byp_q, busy_q;
	logic [MEM_AW-1:0] clr_q;

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= clr_q[7:0];
		end else if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			raw_q      <= mem[rd_addr];
			byp_data_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
			byp_q  <= 1'b0;
		end else begin
			if (busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == MEM_AW'(MEM_BYTES - 1)) begin
					busy_q <= 1'b0;
				end
			end
			if (rd_en) begin
				byp_q <= wr.en && (wr.addr == rd_addr);
			end
		end
	end

	assign rd_data = byp_q ? byp_data_q : raw_q;
	assign busy    = busy_q;

endmodule

`default_nettype wire

>>> sv/five_stage_risc_pipeline_subset_top.sv
// five_stage_risc_pipeline_subset_top: fetch, decode, execute, memory and writeback pipeline
// for add, sub, lb and sb; uses fsrp_pkg, fsrp_regfile and fsrp_dmem
//
// Usage:
//   Each request on the input channel (in_valid, in_stall, instruction) is one clock tick
//   of the processor: the word enters the fetch latch and every older instruction
//   advances one stage. Each request yields exactly one result on the output channel
//   (out_valid, out_stall, wb_* and store_* fields) describing that tick's register
//   writeback and data-memory store.
//   Results are registered: each appears in the cycle after its request is accepted.
//   Throughput: one request per cycle unless stalled; the register file and data memory
//   are read one tick ahead, written in the same cycle, with bypass on same-entry access.
//   Reset: after arst_n releases, the data memory is filled with address modulo 256,
//   one byte a cycle, for MEM_BYTES (2048) cycles with in_stall held high. Register
//   ri reads i plus 256 until first written, r0 is always zero, all latches hold bubbles.
//   Stall: while out_stall holds a waiting result, in_stall is raised and the pipeline
//   holds; the output register keeps its result unchanged.
`default_nettype none

module five_stage_risc_pipeline_subset_top import fsrp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [31:0]       instruction,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   wb_enable,
	output logic [REG_AW-1:0]      wb_register,
	output logic signed [31:0]     wb_value,
	output logic                   store_enable,
	output logic [MEM_AW-1:0]      store_address,
	output logic [7:0]             store_byte
);

	logic step, dm_busy;

	// pipeline latches
	logic [31:0]       fetch_s1;
	dec_kind_t         dec_kind_s2;
	logic [31:0]       dec_rs_s2, dec_rt_s2;
	logic [REG_AW-1:0] dec_dest_s2;
	logic [15:0]       dec_off_s2;
	exe_kind_t         exe_kind_s3;
	logic [31:0]       exe_result_s3;
	logic [7:0]        exe_store_s3;
	logic [REG_AW-1:0] exe_dest_s3;
	logic              wb_kind_s4;
	logic [31:0]       wb_value_s4;
	logic [REG_AW-1:0] wb_dest_s4;

	logic                     out_valid_q, wb_enable_q, store_enable_q;
	logic [REG_AW-1:0]        wb_register_q;
	logic [31:0]              wb_value_q;
	logic [MEM_AW-1:0]        store_address_q;
	logic [7:0]               store_byte_q;

	// decode
	logic [5:0]        op, fn;
	logic [REG_AW-1:0] f_rt, f_rd;
	dec_kind_t         nk;
	logic [REG_AW-1:0] nd;
	logic [31:0]       rs_data, rt_data;

	// writeback, memory, execute
	reg_wr_t           rf_wr;
	mem_wr_t           dm_wr;
	logic [7:0]        dm_rdata;
	logic              nwk;
	logic [31:0]       nwv;
	logic [REG_AW-1:0] nwd;
	exe_kind_t         nek;
	logic [31:0]       ner, sext, ea_full;
	logic [7:0]        nes;
	logic [REG_AW-1:0] ned;
	logic              wen;

	assign step     = in_valid && !in_stall;
	assign in_stall = dm_busy || (out_valid_q && out_stall);

	assign op   = fetch_s1[31:26];
	assign f_rt = fetch_s1[20:16];
	assign f_rd = fetch_s1[15:11];
	assign fn   = fetch_s1[5:0];

	always_comb begin
		nk = DK_BUBBLE;
		nd = '0;
		if (op == OP_RTYPE && fn == FN_ADD) begin
			nk = DK_ADD;
			nd = f_rd;
		end else if (op == OP_RTYPE && fn == FN_SUB) begin
			nk = DK_SUB;
			nd = f_rd;
		end else if (op == OP_LB) begin
			nk = DK_LB;
			nd = f_rt;
		end else if (op == OP_SB) begin
			nk = DK_SB;
		end
	end

	assign wen      = wb_kind_s4 && (wb_dest_s4 != '0);
	assign rf_wr.en   = step && wen;
	assign rf_wr.addr = wb_dest_s4;
	assign rf_wr.data = wb_value_s4;

	always_comb begin
		nwk = 1'b0;
		nwv = '0;
		nwd = '0;
		case (exe_kind_s3)
			EK_ALU: begin
				nwk = 1'b1;
				nwv = exe_result_s3;
				nwd = exe_dest_s3;
			end
			EK_LOAD: begin
				nwk = 1'b1;
				nwv = {{24{dm_rdata[7]}}, dm_rdata};
				nwd = exe_dest_s3;
			end
			default: begin
				nwk = 1'b0;
			end
		endcase
	end

	assign dm_wr.en   = step && (exe_kind_s3 == EK_STORE);
	assign dm_wr.addr = exe_result_s3[MEM_AW-1:0];
	assign dm_wr.data = exe_store_s3;

	assign sext    = {{16{dec_off_s2[15]}}, dec_off_s2};
	assign ea_full = dec_rs_s2 + sext;

	always_comb begin
		nek = EK_BUBBLE;
		ner = '0;
		nes = '0;
		ned = '0;
		case (dec_kind_s2)
			DK_ADD: begin
				nek = EK_ALU;
				ner = dec_rs_s2 + dec_rt_s2;
				ned = dec_dest_s2;
			end
			DK_SUB: begin
				nek = EK_ALU;
				ner = dec_rs_s2 - dec_rt_s2;
				ned = dec_dest_s2;
			end
			DK_LB: begin
				nek = EK_LOAD;
				ner = 32'(ea_full[MEM_AW-1:0]);
				ned = dec_dest_s2;
			end
			DK_SB: begin
				nek = EK_STORE;
				ner = 32'(ea_full[MEM_AW-1:0]);
				nes = dec_rt_s2[7:0];
			end
			default: begin
				nek = EK_BUBBLE;
			end
		endcase
	end

	fsrp_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (step),
		.rs_addr (instruction[25:21]),
		.rt_addr (instruction[20:16]),
		.wr      (rf_wr),
		.rs_data (rs_data),
		.rt_data (rt_data)
	);

	fsrp_dmem u_dmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (step && (dec_kind_s2 == DK_LB)),
		.rd_addr (ner[MEM_AW-1:0]),
		.wr      (dm_wr),
		.rd_data (dm_rdata),
		.busy    (dm_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_s1      <= '0;
			dec_kind_s2   <= DK_BUBBLE;
			dec_rs_s2     <= '0;
			dec_rt_s2     <= '0;
			dec_dest_s2   <= '0;
			dec_off_s2    <= '0;
			exe_kind_s3   <= EK_BUBBLE;
			exe_result_s3 <= '0;
			exe_store_s3  <= '0;
			exe_dest_s3   <= '0;
			wb_kind_s4    <= 1'b0;
			wb_value_s4   <= '0;
			wb_dest_s4    <= '0;
		end else if (step) begin
			fetch_s1      <= instruction;
			dec_kind_s2   <= nk;
			dec_rs_s2     <= rs_data;
			dec_rt_s2     <= rt_data;
			dec_dest_s2   <= nd;
			dec_off_s2    <= fetch_s1[15:0];
			exe_kind_s3   <= nek;
			exe_result_s3 <= ner;
			exe_store_s3  <= nes;
			exe_dest_s3   <= ned;
			wb_kind_s4    <= nwk;
			wb_value_s4   <= nwv;
			wb_dest_s4    <= nwd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			wb_enable_q     <= wen;
			wb_register_q   <= wen ? wb_dest_s4 : '0;
			wb_value_q      <= wen ? wb_value_s4 : '0;
			store_enable_q  <= dm_wr.en;
			store_address_q <= dm_wr.en ? dm_wr.addr : '0;
			store_byte_q    <= dm_wr.en ? dm_wr.data : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign wb_enable     = wb_enable_q;
	assign wb_register   = wb_register_q;
	assign wb_value      = wb_value_q;
	assign store_enable  = store_enable_q;
	assign store_address = store_address_q;
	assign store_byte    = store_byte_q;

	a_no_step_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		dm_busy |-> !step)
		else $error("request accepted during memory fill");

	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid)
		else $error("accepted request produced no result");

	a_no_r0_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && wb_enable) |-> (wb_register != '0))
		else $error("writeback to register zero reported");

	a_store_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !store_enable) |-> (store_address == '0 && store_byte == '0))
		else $error("store fields nonzero without store");

	a_wb_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !wb_enable) |-> (wb_register == '0 && wb_value == '0))
		else $error("writeback fields nonzero without write");

endmodule

`default_nettype wire
